>>> src/crxc_pkg.sv
// ============================================================================
// crxc_pkg
// Shared types and constants of the chunk reverse XOR cipher: controller
// states, command and status bundles, register indexes, mode codes and the
// fixed header key table.
// ============================================================================
package crxc_pkg;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR_CHK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SETUP,
        S_OPEN,
        S_MAP,
        S_EMIT,
        S_HDR_OUT
    } t_state;

    // Class of the byte offered at the input
    typedef enum logic [2:0] {
        K_DROP,
        K_HDR_HOLD,
        K_HDR_LAST,
        K_PASS,
        K_BODY_START,
        K_BODY
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       hdr_check;
        logic       div_start;
        logic       setup;
        logic       open_chunk;
        logic       map;
        logic       emit_body;
        logic       emit_hdr;
        logic [1:0] hdr_idx;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  hdr_match;
        logic  header_found;
        logic  div_done;
        logic  out_free;
    } t_dp_sts;

    // Register indexes
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_KEY_START   = 3'd1;
    localparam logic [2:0] CFG_KEY_STEP    = 3'd2;
    localparam logic [2:0] CFG_CHUNK_LEN   = 3'd3;
    localparam logic [2:0] CFG_BYTE_BUDGET = 3'd4;
    localparam logic [2:0] CFG_FILE_LEN    = 3'd5;

    // Mode codes
    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_DECRYPT = 2'd1;
    localparam logic [1:0] MODE_ENCRYPT = 2'd2;
    localparam logic [1:0] MODE_PASS    = 2'd3;

    // Header signature bytes as they appear in the file
    localparam logic [7:0] SIG_HDR0 = 8'h85 - 8'h20;
    localparam logic [7:0] SIG_HDR1 = 8'ha4 - 8'h40;
    localparam logic [7:0] SIG_HDR2 = 8'hda - 8'h60;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  key;
        logic [7:0]  step;
        logic [15:0] chunk;
        logic [15:0] budget;
    } t_key_row;

    localparam int TABLE_ROWS = 8;

    localparam t_key_row KEY_TABLE [TABLE_ROWS] = '{
        '{8'h5d, 8'h1b, 8'h37, 16'h0040, 16'h2800},
        '{8'h74, 8'h51, 8'he9, 16'h0040, 16'h3000},
        '{8'h71, 8'hc1, 8'h51, 16'h1400, 16'h2000},
        '{8'h8a, 8'h03, 8'h19, 16'h1400, 16'h7800},
        '{8'h95, 8'hab, 8'hcd, 16'h0200, 16'h1000},
        '{8'hb7, 8'h12, 8'h34, 16'h0400, 16'h2800},
        '{8'h9d, 8'h35, 8'h97, 16'h0080, 16'h2800},
        '{8'haa, 8'h99, 8'h37, 16'h0400, 16'h1000}
    };

endpackage

>>> src/crxc_rem_div.sv
// ============================================================================
// crxc_rem_div
// Restoring remainder unit: one dividend bit per cycle, ending in a
// one-cycle done pulse.
// ============================================================================
module crxc_rem_div
    import crxc_pkg::*;
#(
    parameter int SIZE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SIZE_BITS-1:0] i_dividend,
    input  logic [15:0]          i_divisor,
    output logic                 o_done,
    output logic [15:0]          o_rem
);

    localparam int CW = $clog2(SIZE_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [SIZE_BITS-1:0] r_num;
    logic [16:0]          r_rem;
    logic [15:0]          r_div;
    logic [16:0]          w_trial;
    logic [16:0]          w_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        w_trial = {r_rem[15:0], r_num[SIZE_BITS-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_next = w_trial - {1'b0, r_div};
        end else begin
            w_next = w_trial;
        end
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(SIZE_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Hold operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[15:0];

endmodule

>>> src/crxc_datapath.sv
// ============================================================================
// crxc_datapath
// Configuration registers, stream counters, header check, chunk permutation
// and key arithmetic, and the output register of the cipher.
// ============================================================================
module crxc_datapath
    import crxc_pkg::*;
#(
    parameter int SIZE_BITS     = 24,
    parameter int TABLE_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic [7:0]  i_in_byte,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_out_offset,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_file_done,
    output logic        o_header_stripped,
    output logic [2:0]  o_key_entry
);

    localparam int SB         = SIZE_BITS;
    localparam int NUM_SEARCH = (TABLE_ENTRIES < TABLE_ROWS) ? TABLE_ENTRIES : TABLE_ROWS;

    // Configuration
    logic [1:0]  r_mode;
    logic [7:0]  r_key_start;
    logic [7:0]  r_key_step;
    logic [15:0] r_chunk_len;
    logic [23:0] r_byte_budget;
    logic [23:0] r_file_len;

    // Stream state
    logic [SB-1:0] r_bytes_seen;
    logic [7:0]    r_hold [4];
    logic          r_header_found;
    logic [2:0]    r_entry_sel;
    logic [7:0]    r_running_key;
    logic [15:0]   r_chunk_pos;
    logic [15:0]   r_chunk_now;
    logic [SB-1:0] r_chunk_base;
    logic [SB-1:0] r_region_left;
    logic [SB:0]   r_budget_left;

    // Working registers of the current byte
    logic [7:0]    r_byte;
    logic          r_done;
    logic [SB-1:0] r_off;
    logic          r_in_chunk;
    logic [7:0]    r_mul_in;

    // Output register
    logic          r_out_valid;
    logic [23:0]   r_out_offset;
    logic [7:0]    r_out_byte;
    logic          r_out_run_last;
    logic          r_out_file_done;
    logic          r_out_hs;
    logic [2:0]    r_out_entry;

    logic [31:0]   w_fl_wide;
    logic [31:0]   w_bb_wide;
    logic [31:0]   w_off_wide;
    logic [SB-1:0] w_fl;
    logic [SB-1:0] w_size;
    t_key_row      w_row;
    logic [15:0]   w_chunk_raw;
    logic [15:0]   w_chunk;
    logic [7:0]    w_step;
    t_kind         w_kind;
    logic          w_sig_ok;
    logic          w_found;
    logic [2:0]    w_found_sel;
    logic          w_cfg_hit;
    logic [15:0]   w_rem;
    logic          w_div_done;
    logic [SB-1:0] w_tail;
    logic [SB-1:0] w_region;
    logic          w_open_ok;
    logic [15:0]   w_take;
    logic [15:0]   w_half;
    logic [15:0]   w_d;
    logic [15:0]   w_k;
    logic [15:0]   w_prod;
    logic [15:0]   w_close_prod;
    logic [7:0]    w_val;
    logic [16:0]   w_pos_next;
    logic          w_out_free;

    // Fit the size registers to the counter width
    assign w_fl_wide = 32'(r_file_len);
    assign w_bb_wide = 32'(r_byte_budget);
    assign w_fl      = w_fl_wide[SB-1:0];
    assign w_size    = r_header_found ? (w_fl - SB'(4)) : w_fl;

    // Select key parameters of the active source
    always_comb begin
        w_row       = KEY_TABLE[r_entry_sel];
        w_chunk_raw = r_header_found ? w_row.chunk : r_chunk_len;
        w_chunk     = (w_chunk_raw == '0) ? 16'd1 : w_chunk_raw;
        w_step      = r_header_found ? w_row.step : r_key_step;
    end

    // Classify the byte at the input
    always_comb begin
        if (r_bytes_seen >= w_fl) begin
            w_kind = K_DROP;
        end else if (r_mode == MODE_AUTO && w_fl >= SB'(4) && r_bytes_seen < SB'(4)) begin
            w_kind = (r_bytes_seen == SB'(3)) ? K_HDR_LAST : K_HDR_HOLD;
        end else if (r_mode == MODE_PASS || (r_mode == MODE_AUTO && !r_header_found)) begin
            w_kind = K_PASS;
        end else if (!r_header_found && r_bytes_seen == '0) begin
            w_kind = K_BODY_START;
        end else begin
            w_kind = K_BODY;
        end
    end

    // Check signature and search the key table, first hit wins
    always_comb begin
        logic [9:0] want;
        w_sig_ok    = (r_hold[0] == SIG_HDR0) && (r_hold[1] == SIG_HDR1) &&
                      (r_hold[2] == SIG_HDR2);
        w_found     = 1'b0;
        w_found_sel = '0;
        for (int i = 0; i < NUM_SEARCH; i++) begin
            want = 10'(KEY_TABLE[i].id) - 10'((i + 1) * 16);
            if (!w_found && w_sig_ok && 10'(r_hold[3]) == want) begin
                w_found     = 1'b1;
                w_found_sel = 3'(i);
            end
        end
    end

    crxc_rem_div #(
        .SIZE_BITS (SIZE_BITS)
    ) u_rem_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_size),
        .i_divisor  (w_chunk),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Derive tail and encrypted region from the remainder
    always_comb begin
        w_tail = (w_rem < (w_chunk >> 2)) ? SB'(w_rem) : '0;
        w_tail = w_tail + SB'(w_size[0]);
        w_region = (w_size > w_tail) ? (w_size - w_tail) : '0;
    end

    // Decide whether a new chunk opens and how long it is
    always_comb begin
        w_open_ok = (r_chunk_now == '0) && (r_region_left != '0) &&
                    !r_budget_left[SB] && (r_budget_left != '0);
        w_take    = (SB'(w_chunk) > r_region_left) ? r_region_left[15:0] : w_chunk;
    end

    // Map the chunk slot to its output position
    always_comb begin
        w_half = 16'((17'(r_chunk_now) + 17'd1) >> 1);
        w_d    = r_chunk_now - 16'd1 - r_chunk_pos;
        if (r_mode == MODE_ENCRYPT) begin
            w_k = w_d[0] ? (w_half + (w_d >> 1)) : (w_d >> 1);
        end else if (r_chunk_pos < w_half) begin
            w_k = r_chunk_now - 16'd1 - (r_chunk_pos << 1);
        end else begin
            w_k = r_chunk_now - 16'd2 - ((r_chunk_pos - w_half) << 1);
        end
    end

    // Form the output byte and the key advance at chunk end
    always_comb begin
        w_prod       = w_step * r_mul_in;
        w_close_prod = w_step * r_chunk_now[7:0];
        w_val        = r_in_chunk ? (r_byte ^ (r_running_key + w_prod[7:0])) : r_byte;
        w_pos_next   = 17'(r_chunk_pos) + 17'd1;
    end

    assign w_cfg_hit  = i_cfg_valid && (i_cfg_index <= CFG_FILE_LEN);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_AUTO;
            r_key_start   <= '0;
            r_key_step    <= '0;
            r_chunk_len   <= 16'd64;
            r_byte_budget <= 24'd10240;
            r_file_len    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                CFG_KEY_START:   r_key_start   <= i_cfg_data[7:0];
                CFG_KEY_STEP:    r_key_step    <= i_cfg_data[7:0];
                CFG_CHUNK_LEN:   r_chunk_len   <= i_cfg_data[15:0];
                CFG_BYTE_BUDGET: r_byte_budget <= i_cfg_data;
                CFG_FILE_LEN:    r_file_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance stream state; a register write restarts the file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_bytes_seen   <= '0;
            r_header_found <= 1'b0;
            r_entry_sel    <= '0;
            r_running_key  <= '0;
            r_chunk_pos    <= '0;
            r_chunk_now    <= '0;
            r_chunk_base   <= '0;
            r_region_left  <= '0;
            r_budget_left  <= '0;
        end else begin
            if (i_cmd.accept && r_bytes_seen < w_fl) begin
                r_bytes_seen <= r_bytes_seen + SB'(1);
            end
            if (i_cmd.hdr_check && w_found) begin
                r_header_found <= 1'b1;
                r_entry_sel    <= w_found_sel;
            end
            if (i_cmd.setup) begin
                r_region_left <= w_region;
                r_budget_left <= r_header_found ? (SB+1)'(w_row.budget)
                                                : (SB+1)'(w_bb_wide[SB-1:0]);
                r_running_key <= r_header_found ? w_row.key : r_key_start;
                r_chunk_base  <= '0;
                r_chunk_pos   <= '0;
                r_chunk_now   <= '0;
            end
            if (i_cmd.open_chunk && w_open_ok) begin
                r_chunk_now   <= w_take;
                r_region_left <= r_region_left - SB'(w_take);
                r_budget_left <= r_budget_left - (SB+1)'(w_take);
                r_chunk_pos   <= '0;
            end
            if (i_cmd.emit_body && r_in_chunk) begin
                if (w_pos_next >= 17'(r_chunk_now)) begin
                    r_chunk_base  <= r_chunk_base + SB'(r_chunk_now);
                    r_running_key <= r_running_key + w_close_prod[7:0];
                    r_chunk_now   <= '0;
                    r_chunk_pos   <= '0;
                end else begin
                    r_chunk_pos <= w_pos_next[15:0];
                end
            end
        end
    end

    // Capture the byte and its placement
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte     <= i_in_byte;
            r_off      <= r_bytes_seen;
            r_in_chunk <= 1'b0;
            r_done     <= ((SB+1)'(r_bytes_seen) + (SB+1)'(1)) == (SB+1)'(w_fl);
            if (w_kind == K_HDR_HOLD || w_kind == K_HDR_LAST) begin
                r_hold[r_bytes_seen[1:0]] <= i_in_byte;
            end
        end
        if (i_cmd.map) begin
            r_in_chunk <= (r_chunk_now != '0);
            r_mul_in   <= (r_mode == MODE_ENCRYPT) ? w_k[7:0] : r_chunk_pos[7:0];
            if (r_chunk_now != '0) begin
                r_off <= r_chunk_base + SB'(w_k);
            end else if (r_header_found) begin
                r_off <= r_off - SB'(4);
            end
        end
    end

    // Drive the output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_body || i_cmd.emit_hdr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign w_off_wide = 32'(r_off);

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_body) begin
            r_out_offset    <= w_off_wide[23:0];
            r_out_byte      <= w_val;
            r_out_run_last  <= 1'b1;
            r_out_file_done <= r_done;
            r_out_hs        <= r_header_found;
            r_out_entry     <= r_header_found ? r_entry_sel : 3'd0;
        end else if (i_cmd.emit_hdr) begin
            r_out_offset    <= 24'(i_cmd.hdr_idx);
            r_out_byte      <= r_hold[i_cmd.hdr_idx];
            r_out_run_last  <= (i_cmd.hdr_idx == 2'd3);
            r_out_file_done <= (i_cmd.hdr_idx == 2'd3) && r_done;
            r_out_hs        <= 1'b0;
            r_out_entry     <= 3'd0;
        end
    end

    always_comb begin
        o_sts.kind         = w_kind;
        o_sts.hdr_match    = w_found;
        o_sts.header_found = r_header_found;
        o_sts.div_done     = w_div_done;
        o_sts.out_free     = w_out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_offset      = r_out_offset;
    assign o_out_byte        = r_out_byte;
    assign o_run_last        = r_out_run_last;
    assign o_file_done       = r_out_file_done;
    assign o_header_stripped = r_out_hs;
    assign o_key_entry       = r_out_entry;

    // An open chunk never runs past its length
    a_pos_in_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chunk_now != '0) |-> (r_chunk_pos < r_chunk_now))
        else $error("chunk position beyond open chunk");

    // The byte counter never passes the file length
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_seen <= w_fl)
        else $error("byte counter beyond file length");

    // The header is taken only by a header check
    a_found_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_header_found) |-> $past(i_cmd.hdr_check))
        else $error("header flag set outside header check");

    // Header bytes are replayed only when no header was stripped
    a_hdr_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_hdr |-> !r_header_found)
        else $error("header replay after header strip");

endmodule

>>> src/crxc_ctrl.sv
// ============================================================================
// crxc_ctrl
// Controller of the cipher: walks each accepted byte through its steps among
// header check, remainder setup, chunk open, slot mapping and emission.
// ============================================================================
module crxc_ctrl
    import crxc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_hdr_cnt;
    logic [1:0] n_hdr_cnt;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hdr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_hdr_cnt <= n_hdr_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_hdr_cnt = r_hdr_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_sts.kind)
                        K_HDR_LAST:   n_state = S_HDR_CHK;
                        K_PASS:       n_state = S_EMIT;
                        K_BODY_START: n_state = S_DIV_GO;
                        K_BODY:       n_state = S_OPEN;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_HDR_CHK: begin
                n_hdr_cnt = '0;
                n_state   = i_sts.hdr_match ? S_DIV_GO : S_HDR_OUT;
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP:    n_state = i_sts.header_found ? S_IDLE : S_OPEN;
            S_OPEN:     n_state = S_MAP;
            S_MAP:      n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_HDR_OUT: begin
                if (i_sts.out_free) begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                    if (r_hdr_cnt == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.hdr_idx = r_hdr_cnt;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_HDR_CHK:  o_cmd.hdr_check  = 1'b1;
            S_DIV_GO:   o_cmd.div_start  = 1'b1;
            S_DIV_WAIT: ;
            S_SETUP:    o_cmd.setup      = 1'b1;
            S_OPEN:     o_cmd.open_chunk = 1'b1;
            S_MAP:      o_cmd.map        = 1'b1;
            S_EMIT:     o_cmd.emit_body  = i_sts.out_free;
            S_HDR_OUT:  o_cmd.emit_hdr   = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> src/chunk_reverse_xor_cipher_core.sv
// ============================================================================
// chunk_reverse_xor_cipher_core
// Chunk reverse XOR cipher for one file, one byte per input transaction.
// ============================================================================
// Usage:
//   Program the registers over the cfg channel (index 0..5) while idle; any
//   write restarts the file. o_cfg_ready is always high.
//   Feed file bytes in order on the in channel. Each byte yields zero, one
//   or (on a rejected auto header) four result transactions on the out
//   channel, each carrying its output offset; o_run_last marks the last one.
//   A pass-through byte takes accept and emit steps; a byte of the encrypted
//   body takes accept, chunk open, slot map and emit (key multiply) steps of
//   the sequencer. The first body byte also runs the bit-serial remainder
//   unit; in auto mode this runs after the fourth header byte. A rejected
//   header replays its four bytes, one per cycle while the receiver is ready.
//   The output register parts the channels: the next byte is accepted while
//   a result waits; a stalled receiver holds the block in its emit step.
//   Reset (synchronous, active low) loads register defaults and clears the
//   stream counters; no clearing pass is needed.
// ============================================================================
module chunk_reverse_xor_cipher_core
    import crxc_pkg::*;
#(
    parameter int SIZE_BITS     = 24,
    parameter int TABLE_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_out_offset,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_file_done,
    output logic        o_header_stripped,
    output logic [2:0]  o_key_entry
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Accept register writes at any time
    assign o_cfg_ready = 1'b1;

    crxc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    crxc_datapath #(
        .SIZE_BITS     (SIZE_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_byte         (i_in_byte),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_offset      (o_out_offset),
        .o_out_byte        (o_out_byte),
        .o_run_last        (o_run_last),
        .o_file_done       (o_file_done),
        .o_header_stripped (o_header_stripped),
        .o_key_entry       (o_key_entry)
    );

endmodule

>>> verif/crxc_scoreboard.sv
// ============================================================================
// crxc_scoreboard
// Watches the config, input and output channels of the cipher core. It keeps
// its own copy of the registers and the stream state, works out the results
// of every accepted file byte, and compares each output transaction, field by
// field, against the oldest outstanding result.
// ============================================================================
module crxc_scoreboard
    import crxc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_offset,
    input  logic [7:0]  i_out_byte,
    input  logic        i_run_last,
    input  logic        i_file_done,
    input  logic        i_header_stripped,
    input  logic [2:0]  i_key_entry,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [23:0] offset;
        logic [7:0]  data;
        logic        run_last;
        logic        file_done;
        logic        stripped;
        logic [2:0]  entry;
    } t_cipher_out;

    t_cipher_out cipher_queue[$];

    // Register copy
    logic [1:0]  r_mode;
    logic [7:0]  r_key_start;
    logic [7:0]  r_key_step;
    logic [15:0] r_chunk_len;
    logic [23:0] r_budget;
    logic [23:0] r_file_len;

    // Stream state
    int unsigned bytes_seen;
    logic [7:0]  hdr_hold [4];
    logic        hdr_found;
    logic [2:0]  entry_sel;
    logic [7:0]  run_key;
    int unsigned chunk_pos, chunk_now, chunk_base, region_left;
    int          budget_left;

    assign o_pending = cipher_queue.size();

    function automatic int unsigned chunk_size();
        int unsigned c;
        c = hdr_found ? int'(KEY_TABLE[entry_sel].chunk) : int'(r_chunk_len);
        return (c == 0) ? 1 : c;
    endfunction

    function automatic int unsigned key_increment();
        return hdr_found ? int'(KEY_TABLE[entry_sel].step) : int'(r_key_step);
    endfunction

    task automatic clear_stream();
        bytes_seen  = 0;
        hdr_found   = 1'b0;
        entry_sel   = '0;
        run_key     = '0;
        chunk_pos   = 0;
        chunk_now   = 0;
        chunk_base  = 0;
        region_left = 0;
        budget_left = 0;
    endtask

    // Set up tail, region, budget and key for a body of the given size
    task automatic open_body(input int unsigned size);
        int unsigned c, r, tail;
        c = chunk_size();
        r = size % c;
        tail = (r < c / 4) ? r : 0;
        tail += size & 1;
        region_left = (size > tail) ? size - tail : 0;
        budget_left = hdr_found ? int'(KEY_TABLE[entry_sel].budget) : int'(r_budget);
        run_key = hdr_found ? KEY_TABLE[entry_sel].key : r_key_start;
        chunk_base = 0;
        chunk_pos = 0;
        chunk_now = 0;
    endtask

    task automatic push_result(input int unsigned off, input logic [7:0] val,
                               input logic done, input logic last);
        t_cipher_out r;
        r.offset   = off[23:0];
        r.data     = val;
        r.run_last = last;
        r.file_done = done;
        r.stripped = hdr_found;
        r.entry    = hdr_found ? entry_sel : 3'd0;
        cipher_queue.push_back(r);
    endtask

    // Map one body byte to its offset and value
    task automatic cipher_byte(input int unsigned p, input logic [7:0] b, input bit enc,
                               output int unsigned off, output logic [7:0] val);
        int unsigned c, h, j, k, d, stp, mix;
        if (chunk_now == 0 && region_left > 0 && budget_left > 0) begin
            c = chunk_size();
            if (c > region_left) c = region_left;
            chunk_now = c;
            region_left -= c;
            budget_left -= int'(c);
            chunk_pos = 0;
        end
        if (chunk_now == 0) begin
            off = p;
            val = b;
        end else begin
            c = chunk_now;
            h = (c + 1) / 2;
            j = chunk_pos;
            stp = key_increment();
            if (enc) begin
                d = c - 1 - j;
                k = (d[0] == 1'b0) ? d / 2 : h + (d - 1) / 2;
                mix = run_key + stp * k;
            end else begin
                k = (j < h) ? c - 1 - 2 * j : c - 2 - 2 * (j - h);
                mix = run_key + stp * j;
            end
            off = chunk_base + k;
            val = b ^ mix[7:0];
            chunk_pos++;
            if (chunk_pos >= chunk_now) begin
                chunk_base += chunk_now;
                mix = run_key + stp * chunk_now;
                run_key = mix[7:0];
                chunk_now = 0;
            end
        end
    endtask

    // Work out the results of one accepted file byte
    task automatic predict_byte(input logic [7:0] b);
        int unsigned fl, idx, off, want;
        logic [7:0] val;
        logic done;
        bit hit;
        fl = r_file_len;
        if (bytes_seen < fl) begin
            idx = bytes_seen;
            done = (idx + 1 == fl);
            bytes_seen++;
            if (r_mode == MODE_AUTO && fl >= 4 && idx < 4) begin
                hdr_hold[idx] = b;
                if (idx == 3) begin
                    hit = 1'b0;
                    if (hdr_hold[0] == SIG_HDR0 && hdr_hold[1] == SIG_HDR1 &&
                        hdr_hold[2] == SIG_HDR2) begin
                        for (int i = 0; i < TABLE_ROWS && !hit; i++) begin
                            want = int'(KEY_TABLE[i].id) - (i << 4) - 16;
                            if (int'(hdr_hold[3]) == int'(want)) begin
                                hit = 1'b1;
                                hdr_found = 1'b1;
                                entry_sel = i[2:0];
                                open_body(fl - 4);
                            end
                        end
                    end
                    if (!hit) begin
                        for (int i = 0; i < 4; i++)
                            push_result(i, hdr_hold[i], (i == 3) && done, i == 3);
                    end
                end
            end else if (r_mode == MODE_PASS || (r_mode == MODE_AUTO && !hdr_found)) begin
                push_result(idx, b, done, 1'b1);
            end else begin
                if (!hdr_found && idx == 0) open_body(fl);
                cipher_byte(hdr_found ? idx - 4 : idx, b, r_mode == MODE_ENCRYPT, off, val);
                push_result(off, val, done, 1'b1);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_cipher_out got, exp_r;
        if (!i_rst_n) begin
            r_mode      = MODE_AUTO;
            r_key_start = '0;
            r_key_step  = '0;
            r_chunk_len = 16'd64;
            r_budget    = 24'd10240;
            r_file_len  = '0;
            o_fail_count <= 0;
            clear_stream();
        end else begin
            // Compare output transaction with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_offset, i_out_byte, i_run_last, i_file_done,
                        i_header_stripped, i_key_entry};
                if (cipher_queue.size() == 0) begin
                    $display("%0t: unexpected result offset %0h byte %0h",
                             $time, i_out_offset, i_out_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = cipher_queue.pop_front();
                    if (got != exp_r) begin
                        $display({"%0t: mismatch expected off=%0h byte=%0h",
                                  " last=%0b done=%0b hs=%0b ent=%0d"},
                                 $time, exp_r.offset, exp_r.data, exp_r.run_last,
                                 exp_r.file_done, exp_r.stripped, exp_r.entry);
                        $display({"%0t:          actual   off=%0h byte=%0h",
                                  " last=%0b done=%0b hs=%0b ent=%0d"},
                                 $time, got.offset, got.data, got.run_last,
                                 got.file_done, got.stripped, got.entry);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // Apply register writes; each one to index 0..5 restarts the file
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:        r_mode      = i_cfg_data[1:0];
                    CFG_KEY_START:   r_key_start = i_cfg_data[7:0];
                    CFG_KEY_STEP:    r_key_step  = i_cfg_data[7:0];
                    CFG_CHUNK_LEN:   r_chunk_len = i_cfg_data[15:0];
                    CFG_BYTE_BUDGET: r_budget    = i_cfg_data;
                    CFG_FILE_LEN:    r_file_len  = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= CFG_FILE_LEN) clear_stream();
            end
            if (i_in_valid && i_in_ready) predict_byte(i_in_byte);
        end
    end

endmodule

>>> verif/chunk_reverse_xor_cipher_core_tb.sv
// ============================================================================
// chunk_reverse_xor_cipher_core_tb
// Drives files through the cipher core under all modes and register
// extremes: directed cases first (short files, header only, matched and
// rejected headers, zero chunk, zero budget, pass mode), then random files
// with mostly well-formed headers. Both channels stall at random; the
// scoreboard predicts and checks every result.
// ============================================================================
module chunk_reverse_xor_cipher_core_tb;
    import crxc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [23:0] o_out_offset;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_file_done;
    logic        o_header_stripped;
    logic [2:0]  o_key_entry;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          bytes_fed = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    chunk_reverse_xor_cipher_core u_dut (.*);

    crxc_scoreboard u_scoreboard (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in_byte,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_offset(o_out_offset),
        .i_out_byte(o_out_byte), .i_run_last(o_run_last), .i_file_done(o_file_done),
        .i_header_stripped(o_header_stripped), .i_key_entry(o_key_entry),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Stall-free stretch for both sides
    function automatic bit steady();
        return cycle_count >= 1500 && cycle_count < 3500;
    endfunction

    // Count cycles and abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the receiver at random
    always @(posedge i_clk) begin
        i_out_ready <= steady() ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // Hold one register write until it is taken; the caller drops valid
    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        if (!steady() && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Wait until all results are in, then let the block settle
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Program all registers, then stream one file.
    // hdr: 0 random header, 1 signature and key of entry ent, 2 signature with bad key
    task automatic run_file(input logic [1:0] md, input logic [7:0] ks, input logic [7:0] kst,
                            input logic [15:0] chunk, input logic [23:0] budget,
                            input logic [23:0] flen, input int nbytes,
                            input int hdr, input int ent);
        logic [7:0] b;
        logic [7:0] key_byte;
        key_byte = KEY_TABLE[ent].id - 8'(ent << 4) - 8'h10;
        cfg_write(CFG_MODE, {22'd0, md});
        cfg_write(CFG_KEY_START, {16'd0, ks});
        cfg_write(CFG_KEY_STEP, {16'd0, kst});
        cfg_write(CFG_CHUNK_LEN, {8'd0, chunk});
        cfg_write(CFG_BYTE_BUDGET, budget);
        cfg_write(CFG_FILE_LEN, flen);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom_range(255));
            if (hdr != 0 && i == 0) b = SIG_HDR0;
            if (hdr != 0 && i == 1) b = SIG_HDR1;
            if (hdr != 0 && i == 2) b = SIG_HDR2;
            if (hdr == 1 && i == 3) b = key_byte;
            if (hdr == 2 && i == 3) b = 8'hff;
            feed_byte(b);
            if (i < flen) bytes_fed++;
        end
        i_in_valid <= 1'b0;
        drain();
    endtask

    initial begin
        logic [1:0]  md;
        logic [15:0] chunk;
        logic [23:0] budget, flen;
        int          hdr, nb;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty file, short auto file, header only, matched and
        // rejected headers, chunk extremes, zero budget, pass mode
        run_file(MODE_AUTO, 8'h00, 8'h00, 16'd64, 24'd10240, 24'd0, 2, 0, 0);
        run_file(MODE_AUTO, 8'h00, 8'h00, 16'd64, 24'd10240, 24'd3, 3, 0, 0);
        run_file(MODE_AUTO, 8'h00, 8'h00, 16'd64, 24'd10240, 24'd4, 4, 1, 0);
        run_file(MODE_AUTO, 8'h00, 8'h00, 16'd64, 24'd10240, 24'd21, 21, 1, 1);
        run_file(MODE_AUTO, 8'h00, 8'h00, 16'd64, 24'd10240, 24'd6, 6, 2, 0);
        run_file(MODE_DECRYPT, 8'hff, 8'hff, 16'd0, 24'd10240, 24'd7, 7, 0, 0);
        run_file(MODE_ENCRYPT, 8'hff, 8'h01, 16'hffff, 24'hffffff, 24'd6, 6, 0, 0);
        run_file(MODE_DECRYPT, 8'h5a, 8'h03, 16'd4, 24'd0, 24'd5, 5, 0, 0);
        run_file(MODE_PASS, 8'h11, 8'h22, 16'd2, 24'd100, 24'd4, 4, 0, 0);
        run_file(MODE_ENCRYPT, 8'h00, 8'h80, 16'd5, 24'd8, 24'hffffff, 8, 0, 0);

        // Random files, mostly well-formed
        while (bytes_fed < 410) begin
            case ($urandom_range(9))
                0, 1, 2, 3: md = MODE_AUTO;
                4, 5:       md = MODE_DECRYPT;
                6, 7:       md = MODE_ENCRYPT;
                8:          md = ($urandom_range(1)) ? MODE_DECRYPT : MODE_ENCRYPT;
                default:    md = MODE_PASS;
            endcase
            chunk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            case ($urandom_range(3))
                0:       budget = 24'($urandom);
                1:       budget = 24'd0;
                default: budget = 24'($urandom_range(1, 40));
            endcase
            flen = 24'($urandom_range(1, 32));
            hdr = 0;
            if (md == MODE_AUTO) begin
                hdr = ($urandom_range(9) < 8) ? 1 : int'($urandom_range(0, 2));
                if ($urandom_range(3) == 0) flen = 24'($urandom_range(40, 90));
            end
            nb = int'(flen) + (($urandom_range(7) == 0) ? int'($urandom_range(1, 2)) : 0);
            if ($urandom_range(19) == 0) begin
                flen = 24'($urandom) | 24'h800000;
                nb = int'($urandom_range(4, 12));
            end
            run_file(md, 8'($urandom), 8'($urandom), chunk, budget, flen, nb,
                     hdr, int'($urandom_range(0, 7)));
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> chunk_reverse_xor_cipher_core.f
src/crxc_pkg.sv
src/crxc_rem_div.sv
src/crxc_datapath.sv
src/crxc_ctrl.sv
src/chunk_reverse_xor_cipher_core.sv
verif/crxc_scoreboard.sv
verif/chunk_reverse_xor_cipher_core_tb.sv
